// File: src/circular_deque_unit_assert.svh
// ----------------------------------------------------------------------------
// circular_deque_unit_assert.svh
// assertion macros used by the deque top level
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_UNIT_ASSERT_SVH
`define CIRCULAR_DEQUE_UNIT_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define CDQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication checked on the clock after the antecedent
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// implication checked in the same clock as the antecedent
`define CDQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// File: src/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// types and constants of the double-ended queue
// ----------------------------------------------------------------------------
package cdq_pkg;

    // fixed field widths
    localparam int CMD_W     = 2;
    localparam int PORT_DW   = 32;
    localparam int STATUS_W  = 2;
    localparam int CNT_W     = 5;
    localparam int CAP_W     = 5;

    // largest capacity the 5-bit register can hold, and its reset value
    localparam int CAP_LIMIT = (2 ** CAP_W) - 1;
    localparam int CAP_RESET = 16;

    // operation codes of an input item
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_REAR  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_REAR   = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // operation that every cell of the row is told to perform
    typedef enum logic [1:0] {
        OP_HOLD       = 2'd0,
        OP_SHIFT_BACK = 2'd1,
        OP_LOAD_REAR  = 2'd2,
        OP_SHIFT_FWD  = 2'd3
    } t_cell_op;

    // control broadcast from the top level to the cell row
    typedef struct packed {
        t_cell_op         op;
        logic [CNT_W-1:0] count;
    } t_cell_ctl;

endpackage

// File: src/circular_deque_unit.sv
// ----------------------------------------------------------------------------
// circular_deque_unit
// double-ended queue of words with push and pop at both ends
// ----------------------------------------------------------------------------
// The queue accepts one item per clock cycle: an item is taken when start is
// high and busy is low, and its result appears on the o_ ports in the next
// cycle for exactly one cycle, marked by o_strobe. The receiver cannot stall
// the block, so results must be captured when o_strobe is high. Busy is high
// in reset and until r_init is set after it. The words sit in a row of cells
// in queue order, front word in the first cell; a front push or pop shifts
// the whole row, a rear push loads one cell, a rear pop leaves the row as it
// is. A push to a full queue returns status full and changes nothing; a pop
// from an empty queue returns status empty with zero data. Writing the
// capacity register empties the queue; a value of zero is taken as one and a
// value above the cell count is taken as that count. The row has min(DEPTH, 31) cells.
// ----------------------------------------------------------------------------
`include "circular_deque_unit_assert.svh"

module circular_deque_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cdq_pkg::CMD_W-1:0]     i_cmd,
    input  logic [cdq_pkg::PORT_DW-1:0]   i_item_data,
    input  logic                          i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]     i_cfg_wdata,
    output logic                          o_strobe,
    output logic [cdq_pkg::PORT_DW-1:0]   o_out_data,
    output logic [cdq_pkg::STATUS_W-1:0]  o_status,
    output logic [cdq_pkg::CNT_W-1:0]     o_occupancy
);
    import cdq_pkg::*;

    localparam int NCELL = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;
    localparam logic [CAP_W-1:0] CAP_MAX_V = CAP_W'(NCELL);
    localparam logic [CAP_W-1:0] CAP_RST_V = CAP_W'((DEPTH < CAP_RESET) ? DEPTH : CAP_RESET);
    localparam logic [CAP_W-1:0] CAP_MIN_V = CAP_W'(1);

    logic                  r_init;
    logic [CNT_W-1:0]      r_count;
    logic [CAP_W-1:0]      r_cap;
    logic                  r_strobe;
    logic [DATA_WIDTH-1:0] r_out_data;
    t_status               r_status;
    logic [CNT_W-1:0]      r_occ;

    logic [CNT_W-1:0]      n_count;
    logic [CAP_W-1:0]      n_cap;
    logic [DATA_WIDTH-1:0] n_out_data;
    t_status               n_status;

    logic                  accept;
    logic                  full;
    logic                  empty;
    t_cmd                  cmd;
    t_cell_ctl             cell_ctl;
    logic [DATA_WIDTH-1:0] new_word;
    logic [DATA_WIDTH-1:0] rear_word;
    logic [DATA_WIDTH-1:0] cell_data [NCELL];
    logic [DATA_WIDTH-1:0] cell_tap  [NCELL];

    assign busy   = ~r_init;
    assign accept = start & ~busy;
    assign cmd    = t_cmd'(i_cmd);
    assign full   = (r_count >= r_cap);
    assign empty  = (r_count == '0);

    // fit the port word to the stored width
    generate
        if (DATA_WIDTH >= PORT_DW) begin : g_in_wide
            assign new_word = DATA_WIDTH'(i_item_data);
        end else begin : g_in_narrow
            assign new_word = i_item_data[DATA_WIDTH-1:0];
        end
    endgenerate

    // row of cells, first cell holds the front word
    generate
        for (genvar g = 0; g < NCELL; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] left_data;
            logic [DATA_WIDTH-1:0] right_data;
            if (g == 0) begin : g_first
                assign left_data = new_word;
            end else begin : g_inner_left
                assign left_data = cell_data[g-1];
            end
            if (g == NCELL - 1) begin : g_last
                assign right_data = cell_data[g];
            end else begin : g_inner_right
                assign right_data = cell_data[g+1];
            end
            cdq_cell #(
                .CELL_IDX   (g),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl),
                .i_new_data   (new_word),
                .i_left_data  (left_data),
                .i_right_data (right_data),
                .o_data       (cell_data[g]),
                .o_rear_tap   (cell_tap[g])
            );
        end
    endgenerate

    // or the one-hot rear taps together
    always_comb begin
        rear_word = '0;
        for (int k = 0; k < NCELL; k++) begin
            rear_word = rear_word | cell_tap[k];
        end
    end

    // decode the item into a row operation, new count and result
    always_comb begin
        cell_ctl.op    = OP_HOLD;
        cell_ctl.count = r_count;
        n_count        = r_count;
        n_out_data     = '0;
        n_status       = ST_DONE;
        if (accept) begin
            unique case (cmd)
                CMD_PUSH_FRONT: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        cell_ctl.op = OP_SHIFT_BACK;
                        n_count     = r_count + CNT_W'(1);
                    end
                end
                CMD_PUSH_REAR: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        cell_ctl.op = OP_LOAD_REAR;
                        n_count     = r_count + CNT_W'(1);
                    end
                end
                CMD_POP_FRONT: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        cell_ctl.op = OP_SHIFT_FWD;
                        n_out_data  = cell_data[0];
                        n_count     = r_count - CNT_W'(1);
                    end
                end
                CMD_POP_REAR: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_out_data = rear_word;
                        n_count    = r_count - CNT_W'(1);
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    // clamp a written capacity to one..cell count
    always_comb begin
        priority if (i_cfg_wdata == '0) begin
            n_cap = CAP_MIN_V;
        end else if (i_cfg_wdata > CAP_MAX_V) begin
            n_cap = CAP_MAX_V;
        end else begin
            n_cap = i_cfg_wdata;
        end
    end

    // control state: capacity, count and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init   <= 1'b0;
            r_count  <= '0;
            r_cap    <= CAP_RST_V;
            r_strobe <= 1'b0;
        end else begin
            r_init   <= 1'b1;
            r_strobe <= accept;
            if (i_cfg_we) begin
                r_cap   <= n_cap;
                r_count <= '0;
            end else begin
                r_count <= n_count;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
            r_status   <= n_status;
            r_occ      <= n_count;
        end
    end

    // fit the stored width back to the port word
    generate
        if (DATA_WIDTH >= PORT_DW) begin : g_out_wide
            assign o_out_data = r_out_data[PORT_DW-1:0];
        end else begin : g_out_narrow
            assign o_out_data = PORT_DW'(r_out_data);
        end
    endgenerate

    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_occupancy = r_occ;

    // checks on count, capacity and results
    `CDQ_ASSERT_ALWAYS(a_count_le_cap, r_count <= r_cap, "count above capacity")
    `CDQ_ASSERT_ALWAYS(a_cap_range, (r_cap != '0) && (r_cap <= CAP_MAX_V), "capacity out of range")
    `CDQ_ASSERT_NEXT(a_strobe_follows, accept, r_strobe, "accepted item gave no result")
    `CDQ_ASSERT_NEXT(a_no_extra_strobe, !accept, !r_strobe, "result without an item")
    `CDQ_ASSERT_SAME(a_full_occ, r_strobe && (r_status == ST_FULL), r_occ == r_cap, "full status with room left")
    `CDQ_ASSERT_SAME(a_empty_res, r_strobe && (r_status == ST_EMPTY), (r_occ == '0) && (r_out_data == '0), "empty status with data")

endmodule

// File: src/cdq_cell.sv
// ----------------------------------------------------------------------------
// cdq_cell
// one slot of the deque row: holds the word at its position from the front
// ----------------------------------------------------------------------------
module cdq_cell #(
    parameter int CELL_IDX   = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  cdq_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_new_data,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_rear_tap
);
    import cdq_pkg::*;

    // own position, and the count at which this cell holds the rear word
    localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] TAP_IDX = CNT_W'(CELL_IDX + 1);

    logic [DATA_WIDTH-1:0] r_data;

    // slot update: shift toward rear, load at rear, shift toward front
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_SHIFT_BACK: r_data <= i_left_data;
            OP_LOAD_REAR: begin
                if (i_ctl.count == MY_IDX) begin
                    r_data <= i_new_data;
                end
            end
            OP_SHIFT_FWD:  r_data <= i_right_data;
            OP_HOLD:       r_data <= r_data;
            default:       r_data <= r_data;
        endcase
    end

    assign o_data = r_data;

    // drive the rear word onto the or-tree when this cell holds the last occupied word
    assign o_rear_tap = (i_ctl.count == TAP_IDX) ? r_data : '0;

endmodule
